// ===== rtl/ctf_pkg.sv =====
// ----------------------------------------------------------------------------
// ctf_pkg
// shared types and constants of the capture timestamp fifo
// ----------------------------------------------------------------------------
`default_nettype none
package ctf_pkg;

  localparam int unsigned StampW  = 64;
  localparam int unsigned FramesW = 24;
  localparam int unsigned RateW   = 20;
  localparam int unsigned CapW    = 10;
  localparam int unsigned ProdW   = 54;  // frames times ns per second
  localparam int unsigned EntryW  = StampW + FramesW;

  localparam logic [29:0] NsPerSec   = 30'd1000000000;
  localparam logic [RateW-1:0] RateReset = 20'd48000;
  localparam logic [CapW-1:0]  CapReset  = 10'd512;

  typedef enum logic {
    CFG_OUT_RATE = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_index_e;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_READ = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD,
    ST_HEAD,
    ST_DIV_FIRST,
    ST_DIV_NEXT,
    ST_DIV_EXT,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/ctf_ram.sv =====
// ----------------------------------------------------------------------------
// ctf_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module ctf_ram #(
  parameter int unsigned WIDTH = 88,
  parameter int unsigned DEPTH = 512
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire                      re_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ctf_ns_div.sv =====
// ----------------------------------------------------------------------------
// ctf_ns_div
// frames to nanoseconds: multiply by 1e9, then restoring divide by the rate
// ----------------------------------------------------------------------------
`default_nettype none
module ctf_ns_div (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire [ctf_pkg::FramesW-1:0] frames_i,
  input  wire [ctf_pkg::RateW-1:0]   rate_i,
  output logic                      done_o,
  output logic [ctf_pkg::ProdW-1:0]  quot_o
);
  import ctf_pkg::*;

  localparam int unsigned CntW = $clog2(ProdW + 1);

  logic [ProdW-1:0] prod_q, prod_d;
  logic [RateW-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RateW:0]   trial;
  logic             ge;

  assign trial = {rem_q, prod_q[ProdW-1]};
  assign ge    = trial >= {1'b0, rate_i};

  always_comb begin
    prod_d = prod_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      prod_d = ProdW'({30'd0, frames_i} * {24'd0, NsPerSec});
      rem_d  = '0;
      cnt_d  = CntW'(ProdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit a cycle, shifted in where the dividend leaves
      prod_d = {prod_q[ProdW-2:0], ge};
      rem_d  = ge ? RateW'(trial - {1'b0, rate_i}) : trial[RateW-1:0];
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = prod_q;

endmodule
`default_nettype wire

// ===== rtl/capture_timestamp_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// capture_timestamp_fifo_unit
// ring of (capture stamp, frame count) entries with frame-accurate read stamps
// ----------------------------------------------------------------------------
// push and zero-count items go from accept straight to the done state and the result register
// read: each entry reached takes check, ram read, head update and a divide; the first
//   stamp takes a further divide, a dry ring one more, then the result register
// the bit-serial ns divider (54 quotient bits) sets the pace of reads; the result register
//   lets the next item in while a result waits
// reset clears indexes, count, head offset and next stamp; ring ram is not cleared
`default_nettype none
module capture_timestamp_fifo_unit #(
  parameter int unsigned DEPTH = 512
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,   // 0 out_rate_hz, 1 capacity_in_use
  input  wire  [19:0] cfg_data_i,
  // input items
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [87:0] s_axis_tdata,  // stamp_ns [63:0], frame_count [87:64]
  input  wire         s_axis_tuser,  // req_type
  // result items
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [63:0] m_axis_tdata,  // first_stamp_ns [63:0]
  output logic [1:0]  m_axis_tuser   // push_dropped [0], extrapolated [1]
);
  import ctf_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned ExtW = (CntW > CapW) ? CntW : CapW;

  // configuration registers
  logic [RateW-1:0] rate_q;
  logic [CapW-1:0]  cap_q;
  logic [RateW-1:0] rate_eff;
  logic [CntW-1:0]  cap_eff;
  logic [ExtW-1:0]  cap_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RateReset;
      cap_q  <= CapReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_OUT_RATE: rate_q <= cfg_data_i;
        CFG_CAPACITY: cap_q  <= cfg_data_i[CapW-1:0];
        default: ;
      endcase
    end
  end

  // zero rate acts as one, capacity is clamped into 1..DEPTH
  assign rate_eff = (rate_q == '0) ? RateW'(1) : rate_q;
  assign cap_ext  = ExtW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CntW'(1);
    end else if (cap_ext > ExtW'(DEPTH)) begin
      cap_eff = CntW'(DEPTH);
    end else begin
      cap_eff = cap_ext[CntW-1:0];
    end
  end

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx,
                                               input logic [CntW-1:0] cap);
    logic [CntW-1:0] n;
    n = CntW'(idx) + 1'b1;
    return (n >= cap) ? '0 : n[IdxW-1:0];
  endfunction

  // input fields
  logic [StampW-1:0]  in_stamp;
  logic [FramesW-1:0] in_frames;
  assign in_stamp  = s_axis_tdata[63:0];
  assign in_frames = s_axis_tdata[87:64];

  // control state
  state_e             state_q, state_d;
  logic [IdxW-1:0]    widx_q, ridx_q;
  logic [CntW-1:0]    cnt_q;
  logic [FramesW-1:0] used_q;
  logic [StampW-1:0]  next_stamp_q;
  logic [FramesW-1:0] remain_q;
  logic               have_first_q;

  // per-item payload
  logic [StampW-1:0]  first_q;
  logic               drop_q, extrap_q;
  logic [StampW-1:0]  es_q;
  logic [FramesW-1:0] ef_q;

  logic in_fire, full, out_free;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign full     = cnt_q >= cap_eff;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // head entry consumption
  logic [FramesW-1:0] left, take, used_new;
  logic               pop;
  assign left     = (used_q < ef_q) ? ef_q - used_q : '0;
  assign take     = (remain_q < left) ? remain_q : left;
  assign used_new = used_q + take;
  assign pop      = used_new >= ef_q;

  // ram and divider
  logic               ram_we, ram_re;
  logic [EntryW-1:0]  ram_rdata;
  logic               div_start, div_done;
  logic [FramesW-1:0] div_frames;
  logic [ProdW-1:0]   div_quot;
  logic [StampW-1:0]  div_ns;
  assign div_ns = StampW'(div_quot);

  ctf_ram #(
    .WIDTH (EntryW),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i ({in_frames, in_stamp}),
    .re_i    (ram_re),
    .raddr_i (ridx_q),
    .rdata_o (ram_rdata)
  );

  ctf_ns_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .frames_i (div_frames),
    .rate_i   (rate_eff),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_frames != '0 && req_type_e'(s_axis_tuser) == REQ_READ) begin
            state_d = ST_CHECK;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CHECK:     state_d = (cnt_q == '0) ? ST_DIV_EXT : ST_RD;
      ST_RD:        state_d = ST_HEAD;
      ST_HEAD:      state_d = have_first_q ? ST_DIV_NEXT : ST_DIV_FIRST;
      ST_DIV_FIRST: if (div_done) state_d = ST_HEAD;
      ST_DIV_NEXT: begin
        if (div_done) state_d = (remain_q != '0) ? ST_CHECK : ST_DONE;
      end
      ST_DIV_EXT:   if (div_done) state_d = ST_DONE;
      ST_DONE:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    div_start     = 1'b0;
    div_frames    = used_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_we = s_axis_tvalid && in_frames != '0 && !full
                 && req_type_e'(s_axis_tuser) == REQ_PUSH;
      end
      ST_CHECK: begin
        ram_re = cnt_q != '0;
        // dry ring: extrapolate over what is left of the read
        div_start  = cnt_q == '0;
        div_frames = remain_q;
      end
      ST_HEAD: begin
        div_start = 1'b1;
        if (!have_first_q) begin
          div_frames = used_q;
        end else begin
          div_frames = pop ? ef_q : used_new;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      widx_q        <= '0;
      ridx_q        <= '0;
      cnt_q         <= '0;
      used_q        <= '0;
      next_stamp_q  <= '0;
      have_first_q  <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          have_first_q <= 1'b0;
          if (ram_we) begin
            widx_q <= next_idx(widx_q, cap_eff);
            cnt_q  <= cnt_q + 1'b1;
          end
        end
        ST_HEAD: begin
          if (have_first_q) begin
            if (pop) begin
              ridx_q <= next_idx(ridx_q, cap_eff);
              cnt_q  <= cnt_q - 1'b1;
              used_q <= '0;
            end else begin
              used_q <= used_new;
            end
          end
        end
        ST_DIV_FIRST: if (div_done) have_first_q <= 1'b1;
        ST_DIV_NEXT:  if (div_done) next_stamp_q <= es_q + div_ns;
        ST_DIV_EXT:   if (div_done) next_stamp_q <= next_stamp_q + div_ns;
        default: ;
      endcase
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          first_q  <= '0;
          extrap_q <= 1'b0;
          remain_q <= in_frames;
          drop_q   <= in_frames != '0 && full && req_type_e'(s_axis_tuser) == REQ_PUSH;
        end
      end
      ST_CHECK: begin
        if (cnt_q == '0 && !have_first_q) first_q <= next_stamp_q;
      end
      ST_RD: begin
        es_q <= ram_rdata[StampW-1:0];
        ef_q <= ram_rdata[EntryW-1:StampW];
      end
      ST_HEAD:      if (have_first_q) remain_q <= remain_q - take;
      ST_DIV_FIRST: if (div_done) first_q <= es_q + div_ns;
      ST_DIV_EXT:   if (div_done) extrap_q <= 1'b1;
      ST_DONE: begin
        if (out_free) begin
          m_axis_tdata <= first_q;
          m_axis_tuser <= {extrap_q, drop_q};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input taken while an item is in work");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count beyond ring depth");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("dropped and extrapolated both set");
  a_ram_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("ring written and read in one cycle");
`endif

endmodule
`default_nettype wire

// ===== tb/capture_timestamp_fifo_unit_tb.sv =====
// ----------------------------------------------------------------------------
// capture_timestamp_fifo_unit_tb
// self-checking bench: predicts every result item from its own ring model
// ----------------------------------------------------------------------------
// pushes and reads are generated ahead of time and run through the predictor
// while they are queued, so the expected results line up with the item order.
// a clocked driver feeds the input stream from that queue, a clocked monitor
// compares each result item field by field. configuration changes happen
// only with nothing in flight, one phase per setting, idling varied by phase.
`default_nettype none
module capture_timestamp_fifo_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ctf_pkg::*;

  localparam int unsigned RingDepth  = 512;
  localparam int unsigned StallLimit = 200000;  // cycles with no handshake at all

  typedef struct {
    req_type_e   kind;
    logic [63:0] stamp;
    logic [23:0] frames;
  } chunk_req_t;

  typedef struct {
    logic [63:0] first_stamp;
    logic        dropped;
    logic        extrap;
  } stamp_result_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // dut ports, all inputs known from time zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [19:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  capture_timestamp_fifo_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // stimulus and expectation stores
  chunk_req_t    chunk_q[$];
  stamp_result_t stamp_exp_q[$];
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   mismatches = 0;
  logic          in_fire = 1'b0;

  // ring model state
  logic [63:0] stamp_ring [RingDepth];
  logic [23:0] frame_ring [RingDepth];
  bit          ring_written [RingDepth];
  int unsigned wr_idx, rd_idx, held, head_used;
  logic [63:0] next_ns;
  logic [19:0] rate_reg;
  logic [9:0]  cap_reg;

  // capacity 0 behaves as 1, anything past the ring size as the ring size
  function automatic int unsigned eff_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > RingDepth) return RingDepth;
    return cap_reg;
  endfunction

  function automatic int unsigned ring_next(int unsigned idx);
    return (idx + 1 >= eff_cap()) ? 0 : idx + 1;
  endfunction

  function automatic logic [63:0] count_to_ns(logic [23:0] frames);
    longint unsigned rate;
    rate = (rate_reg == 0) ? 64'd1 : 64'(rate_reg);
    return (64'(frames) * 64'd1000000000) / rate;
  endfunction

  // dry walk of a read: true when it only touches entries written so far
  function automatic bit read_stays_on_written(logic [23:0] frames);
    int unsigned rem, ri, cnt, used, ef, take;
    rem = frames; ri = rd_idx; cnt = held; used = head_used;
    while (rem > 0 && cnt > 0) begin
      if (!ring_written[ri % RingDepth]) return 0;
      ef = frame_ring[ri % RingDepth];
      take = (used < ef) ? ef - used : 0;
      if (rem < take) take = rem;
      used += take;
      rem -= take;
      if (used >= ef) begin
        ri = ring_next(ri);
        cnt--;
        used = 0;
      end
    end
    return 1;
  endfunction

  function automatic stamp_result_t predict_step(chunk_req_t req);
    stamp_result_t res;
    bit            have_first;
    int unsigned   rem, slot, ef, take;
    logic [63:0]   es;
    res = '{default: '0};
    have_first = 0;
    if (req.frames != 0) begin
      if (req.kind == REQ_PUSH) begin
        if (held >= eff_cap()) begin
          res.dropped = 1'b1;
        end else begin
          slot = wr_idx % RingDepth;
          stamp_ring[slot] = req.stamp;
          frame_ring[slot] = req.frames;
          ring_written[slot] = 1;
          wr_idx = ring_next(wr_idx);
          held++;
        end
      end else begin
        rem = req.frames;
        while (rem > 0) begin
          if (held == 0) begin
            // ring ran dry: continue from the stamp after the last frame
            if (!have_first) res.first_stamp = next_ns;
            have_first = 1;
            next_ns += count_to_ns(24'(rem));
            res.extrap = 1'b1;
            break;
          end
          slot = rd_idx % RingDepth;
          es = stamp_ring[slot];
          ef = frame_ring[slot];
          // a stale head (offset past its frames) yields nothing and is popped
          take = (head_used < ef) ? ef - head_used : 0;
          if (!have_first) res.first_stamp = es + count_to_ns(24'(head_used));
          have_first = 1;
          if (rem < take) take = rem;
          head_used += take;
          rem -= take;
          if (head_used >= ef) begin
            rd_idx = ring_next(rd_idx);
            held--;
            head_used = 0;
            next_ns = es + count_to_ns(24'(ef));
          end else begin
            next_ns = es + count_to_ns(24'(head_used));
          end
        end
      end
    end
    return res;
  endfunction

  // queue one item with its prediction; a read that would reach a never
  // written entry is turned into a push
  task automatic queue_chunk(req_type_e kind, logic [63:0] stamp, logic [23:0] frames);
    chunk_req_t req;
    req = '{kind: kind, stamp: stamp, frames: frames};
    if (kind == REQ_READ && frames != 0 && !read_stays_on_written(frames))
      req.kind = REQ_PUSH;
    chunk_q.push_back(req);
    stamp_exp_q.push_back(predict_step(req));
  endtask

  task automatic wait_drained();
    while (chunk_q.size() != 0 || stamp_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [19:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready) break;
    end
    if (idx == CFG_OUT_RATE) rate_reg = value;
    else cap_reg = value[9:0];
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_stamp();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_phase(logic [19:0] rate, logic [9:0] cap, int unsigned idle,
                              int unsigned stall, int unsigned n_items);
    int unsigned pick;
    logic [23:0] frames;
    wait_drained();
    write_reg(CFG_OUT_RATE, rate);
    write_reg(CFG_CAPACITY, 20'(cap));
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        queue_chunk(req_type_e'($urandom_range(1)), rand_stamp(), 24'd0);
      end else if (pick < 62) begin
        frames = ($urandom_range(19) == 0) ? 24'($urandom()) : 24'($urandom_range(1, 256));
        if (frames == 0) frames = 24'd1;
        queue_chunk(REQ_PUSH, rand_stamp(), frames);
      end else begin
        frames = ($urandom_range(29) == 0) ? 24'($urandom()) : 24'($urandom_range(1, 400));
        if (frames == 0) frames = 24'd1;
        queue_chunk(REQ_READ, rand_stamp(), frames);
      end
    end
  endtask

  // input driver: changes on the falling edge, holds an item until taken
  always @(negedge clk_i) begin : drive_items
    chunk_req_t req;
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (chunk_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = chunk_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {req.frames, req.stamp};
          s_axis_tuser  <= req.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor and watchdog, sampled on the rising edge
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin : watch_results
    stamp_result_t want;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (m_axis_tvalid && m_axis_tready) begin
      if (stamp_exp_q.size() == 0) begin
        $display("%0t: result item with nothing expected: stamp %h flags %b",
                 $realtime, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = stamp_exp_q.pop_front();
        if (m_axis_tdata !== want.first_stamp) begin
          $display("%0t: first_stamp_ns expected %h actual %h",
                   $realtime, want.first_stamp, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.dropped) begin
          $display("%0t: push_dropped expected %b actual %b",
                   $realtime, want.dropped, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== want.extrap) begin
          $display("%0t: extrapolated expected %b actual %b",
                   $realtime, want.extrap, m_axis_tuser[1]);
          mismatches++;
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $realtime, StallLimit);
      $display("** capture_timestamp_fifo_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wr_idx = 0; rd_idx = 0; held = 0; head_used = 0; next_ns = '0;
    rate_reg = RateReset;
    cap_reg = CapReset;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero counts, dry ring, extreme fields, walks across entries
    queue_chunk(REQ_PUSH, rand_stamp(), 24'd0);
    queue_chunk(REQ_READ, rand_stamp(), 24'd0);
    queue_chunk(REQ_READ, '0, 24'd100);
    queue_chunk(REQ_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF);
    queue_chunk(REQ_READ, '0, 24'd5);
    queue_chunk(REQ_READ, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF);
    queue_chunk(REQ_PUSH, 64'd1000, 24'd48);
    queue_chunk(REQ_PUSH, 64'd2000, 24'd48);
    queue_chunk(REQ_READ, '0, 24'd30);
    queue_chunk(REQ_READ, '0, 24'd40);
    queue_chunk(REQ_READ, '0, 24'd100);
    wait_drained();

    // tiny ring: full ring drop, then growing it lets a push land on the
    // partly read head, which then reads as stale
    write_reg(CFG_CAPACITY, 20'd2);
    queue_chunk(REQ_PUSH, rand_stamp(), 24'd10);
    queue_chunk(REQ_PUSH, rand_stamp(), 24'd10);
    queue_chunk(REQ_READ, '0, 24'd15);
    queue_chunk(REQ_PUSH, rand_stamp(), 24'd10);
    queue_chunk(REQ_PUSH, rand_stamp(), 24'd10);
    wait_drained();
    write_reg(CFG_CAPACITY, 20'd512);
    queue_chunk(REQ_PUSH, rand_stamp(), 24'd1);
    queue_chunk(REQ_READ, '0, 24'd3);
    queue_chunk(REQ_READ, '0, 24'd7);

    // random phases: rate and capacity extremes, idling patterns per phase
    random_phase(20'd1,      10'd4,    0,  0,  80);
    random_phase(20'd768000, 10'd512,  57, 0,  120);
    random_phase(20'd0,      10'd0,    0,  57, 60);
    random_phase(20'd44100,  10'd1023, 29, 29, 150);
    random_phase(20'($urandom_range(1, 768000)), 10'd16, 0, 0, 120);
    random_phase(20'd96000,  10'd7,    57, 57, 120);
    wait_drained();
    repeat (200) @(posedge clk_i);

    if (mismatches == 0 && stamp_exp_q.size() == 0) begin
      $display("** capture_timestamp_fifo_unit: PASSED **");
    end else begin
      $display("** capture_timestamp_fifo_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== capture_timestamp_fifo_unit.f =====
rtl/ctf_pkg.sv
rtl/ctf_ram.sv
rtl/ctf_ns_div.sv
rtl/capture_timestamp_fifo_unit.sv
tb/capture_timestamp_fifo_unit_tb.sv
